FILE: rtl/bclpd_pkg.sv
// Shared types and constants for the button click and long-press detector.
package bclpd_pkg;

  localparam int PAD_W     = 6;
  localparam int MASK_W    = 40;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUR_W-1:0] DEBOUNCE_RST   = 16'd500;
  localparam logic [DUR_W-1:0] LONG_CLICK_RST = 16'd3000;

  // Operation codes of an input word
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Click kinds of a result word
  localparam logic CLICK_SHORT = 1'b0;
  localparam logic CLICK_LONG  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_CLICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [PAD_W-1:0] pad;
    logic             level;
  } in_word_t;

  typedef struct packed {
    logic [PAD_W-1:0] event_pad;
    logic             click_kind;
    logic [DUR_W-1:0] press_ms;
  } out_word_t;

  // One pad's time stamps, kept together in the pad memory
  typedef struct packed {
    logic [TIME_W-1:0] last_event;
    logic [TIME_W-1:0] press_start;
  } pad_entry_t;

endpackage

FILE: rtl/bclpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bclpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/button_click_long_press_detector_core.sv
// Top level of the button click and long-press detector.
// A result word passes the evaluate stage, then the output register that drives out_valid.
// Throughput: one word per cycle unless a click waits on out_stall; the pad memory is read
// at acceptance, written back from the evaluate stage and forwarded to a next same-pad word.
// Reset (synchronous, rst_n low): registers return to their defaults, time and all pad state
// clear at once through per-pad valid bits; no clearing pass is needed.
module button_click_long_press_detector_core
  import bclpd_pkg::*;
#(
  parameter int NUM_PADS = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample / tick words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  // click result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PAD_AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam logic [PAD_W:0] PAD_LIMIT = (PAD_W+1)'(NUM_PADS);
  localparam int WIDE_W = 1 << PAD_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DUR_W-1:0]  debounce_r,   debounce_nxt;
  logic [DUR_W-1:0]  long_click_r, long_click_nxt;
  logic [MASK_W-1:0] active_low_r, active_low_nxt;
  logic [MASK_W-1:0] enable_r,     enable_nxt;
  logic              mask_wr;

  always_comb begin
    debounce_nxt   = debounce_r;
    long_click_nxt = long_click_r;
    active_low_nxt = active_low_r;
    enable_nxt     = enable_r;
    mask_wr        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_nxt   = cfg_wdata[DUR_W-1:0];
        CFG_LONG_CLICK: long_click_nxt = cfg_wdata[DUR_W-1:0];
        CFG_ACTIVE_LOW: begin
          active_low_nxt = cfg_wdata[MASK_W-1:0];
          mask_wr        = 1'b1;
        end
        CFG_ENABLE:     enable_nxt     = cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Masks widened to the full pad code range; pads past the mask read as zero
  logic [WIDE_W-1:0] active_low_wide, enable_wide, pol_change_wide;
  assign active_low_wide = WIDE_W'(active_low_r);
  assign enable_wide     = WIDE_W'(enable_r);
  assign pol_change_wide = WIDE_W'(active_low_r ^ active_low_nxt);

  // ---------------------------------------------------------------------
  // Stage 1: evaluate stage, holds the word whose memory read is in flight
  // ---------------------------------------------------------------------
  logic       s1_valid_r, s1_valid_nxt;
  in_word_t   s1_word_r;
  logic       s1_adv;
  logic       in_acc;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r;
  logic       out_free;

  // Per-pad flag registers
  logic [NUM_PADS-1:0] pressing_r,   pressing_nxt;
  logic [NUM_PADS-1:0] prev_level_r, prev_level_nxt;
  logic [NUM_PADS-1:0] entry_ok_r,   entry_ok_nxt;
  logic [TIME_W-1:0]   time_r,       time_nxt;

  // Pad memory ports
  logic                 ram_we;
  logic [PAD_AW-1:0]    ram_waddr, ram_raddr;
  pad_entry_t           ram_wdata, ram_rdata;

  // Forwarding of the write made at the previous edge
  logic                 fwd_valid_r;
  logic [PAD_AW-1:0]    fwd_addr_r;
  pad_entry_t           fwd_data_r;

  // Evaluate-stage decode
  logic [PAD_AW-1:0]  s1_idx;
  logic               s1_pad_ok, s1_sample, s1_tick;
  logic               s1_en, s1_act, s1_lvl_act;
  pad_entry_t         s1_entry, s1_entry_new;
  logic [TIME_W-1:0]  since_event, dur;
  logic               start_press, finish_press;
  out_word_t          result;

  assign out_free  = !out_valid_r || !out_stall;
  // hold the evaluate stage only when it has a result and the output is blocked
  assign s1_adv    = !(s1_valid_r && finish_press && !out_free);
  assign in_stall  = !s1_adv;
  assign in_acc    = in_valid && !in_stall;

  assign s1_idx    = s1_word_r.pad[PAD_AW-1:0];
  assign s1_pad_ok = {1'b0, s1_word_r.pad} < PAD_LIMIT;
  assign s1_tick   = s1_valid_r && (s1_word_r.operation == OP_TICK);
  assign s1_sample = s1_valid_r && (s1_word_r.operation == OP_SAMPLE) && s1_pad_ok;
  assign s1_en     = enable_wide[s1_word_r.pad];
  assign s1_act    = ~active_low_wide[s1_word_r.pad];
  assign s1_lvl_act = (s1_word_r.level == s1_act);

  // Pick the freshest copy of the pad entry; a never-written entry reads as zero
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_idx)) begin
      s1_entry = fwd_data_r;
    end else if (entry_ok_r[s1_idx]) begin
      s1_entry = ram_rdata;
    end else begin
      s1_entry = '0;
    end
  end

  assign since_event = time_r - s1_entry.last_event;
  assign dur         = time_r - s1_entry.press_start;

  assign start_press  = s1_sample && s1_en && s1_lvl_act && !pressing_r[s1_idx] &&
                        (prev_level_r[s1_idx] != s1_act) &&
                        (since_event > TIME_W'(debounce_r));
  assign finish_press = s1_sample && s1_en && !s1_lvl_act && pressing_r[s1_idx];

  always_comb begin
    result.event_pad  = s1_word_r.pad;
    result.click_kind = (dur >= TIME_W'(long_click_r)) ? CLICK_LONG : CLICK_SHORT;
    result.press_ms   = (dur > TIME_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : dur[DUR_W-1:0];
  end

  // Modify the entry: stamp the start of a press, or the end of one
  always_comb begin
    s1_entry_new = s1_entry;
    if (start_press) begin
      s1_entry_new.press_start = time_r;
    end
    if (finish_press) begin
      s1_entry_new.last_event = time_r;
    end
  end

  assign ram_we    = s1_adv && (start_press || finish_press);
  assign ram_waddr = s1_idx;
  assign ram_wdata = s1_entry_new;
  // re-read the held pad while stalled so the stage sees the current entry
  assign ram_raddr = s1_adv ? in_word.pad[PAD_AW-1:0] : s1_idx;

  bclpd_ram #(
    .WIDTH ($bits(pad_entry_t)),
    .DEPTH (NUM_PADS)
  ) u_pad_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next values of time, per-pad flags and pipeline control
  always_comb begin
    time_nxt       = time_r;
    pressing_nxt   = pressing_r;
    prev_level_nxt = prev_level_r;
    entry_ok_nxt   = entry_ok_r;
    s1_valid_nxt   = s1_adv ? in_acc : s1_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (s1_adv) begin
      if (s1_tick) begin
        time_nxt = time_r + 1'b1;
      end
      if (s1_sample) begin
        prev_level_nxt[s1_idx] = s1_word_r.level;
        if (!s1_en || finish_press) begin
          pressing_nxt[s1_idx] = 1'b0;
        end
        if (start_press) begin
          pressing_nxt[s1_idx] = 1'b1;
        end
      end
      if (ram_we) begin
        entry_ok_nxt[s1_idx] = 1'b1;
      end
      if (finish_press) begin
        out_valid_nxt = 1'b1;
      end
    end

    // Polarity write: every pad falls back to its inactive level,
    // drop presses on pads whose polarity flipped
    if (mask_wr) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        prev_level_nxt[p] = active_low_wide[p] ^ pol_change_wide[p];
        if (pol_change_wide[p]) begin
          pressing_nxt[p] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_click_r <= LONG_CLICK_RST;
      active_low_r <= '0;
      enable_r     <= '0;
      time_r       <= '0;
      pressing_r   <= '0;
      prev_level_r <= '0;
      entry_ok_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_valid_r  <= 1'b0;
    end else begin
      debounce_r   <= debounce_nxt;
      long_click_r <= long_click_nxt;
      active_low_r <= active_low_nxt;
      enable_r     <= enable_nxt;
      time_r       <= time_nxt;
      pressing_r   <= pressing_nxt;
      prev_level_r <= prev_level_nxt;
      entry_ok_r   <= entry_ok_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      fwd_valid_r  <= ram_we;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_word_r <= in_word;
    end
    if (ram_we) begin
      fwd_addr_r <= ram_waddr;
      fwd_data_r <= ram_wdata;
    end
    if (s1_adv && finish_press) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sim/click_tb_pkg.sv
// Click scoreboard: per-pad press tracking and expected click words for the detector bench.
package click_tb_pkg;
  import bclpd_pkg::*;

  localparam int PADS = 40;

  class click_scoreboard;
    logic [DUR_W-1:0]  debounce;
    logic [DUR_W-1:0]  long_click;
    logic [MASK_W-1:0] active_low;
    logic [MASK_W-1:0] enable;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] last_event [PADS];
    logic [TIME_W-1:0] press_start [PADS];
    bit                pressing [PADS];
    bit                prev_level [PADS];
    out_word_t         pending_clicks[$];
    int                errors;
    int                clicks_checked;
    int                long_clicks;

    function new();
      debounce   = DEBOUNCE_RST;
      long_click = LONG_CLICK_RST;
      active_low = '0;
      enable     = '0;
      now_ms     = '0;
      foreach (last_event[p]) begin
        last_event[p]  = '0;
        press_start[p] = '0;
        pressing[p]    = 1'b0;
        prev_level[p]  = 1'b0;
      end
    endfunction

    function bit active_level(int p);
      return !active_low[p];
    endfunction

    function int pending();
      return pending_clicks.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      logic [MASK_W-1:0] flipped;
      case (idx)
        CFG_DEBOUNCE:   debounce   = data[DUR_W-1:0];
        CFG_LONG_CLICK: long_click = data[DUR_W-1:0];
        CFG_ACTIVE_LOW: begin
          // a polarity write re-arms every pad and drops presses whose polarity flipped
          flipped    = active_low ^ data[MASK_W-1:0];
          active_low = data[MASK_W-1:0];
          foreach (prev_level[p]) begin
            prev_level[p] = active_low[p];
            if (flipped[p]) pressing[p] = 1'b0;
          end
        end
        CFG_ENABLE:     enable = data[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(in_word_t w);
      int                p;
      bit                act;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] dur;
      out_word_t         click;
      if (w.operation == OP_TICK) begin
        now_ms = now_ms + 1;
        return;
      end
      if (w.pad >= PADS) return;
      p = w.pad;
      if (!enable[p]) begin
        prev_level[p] = w.level;
        pressing[p]   = 1'b0;
        return;
      end
      act = active_level(p);
      if (w.level == act) begin
        elapsed = now_ms - last_event[p];
        if (!pressing[p] && prev_level[p] != act && elapsed > TIME_W'(debounce)) begin
          pressing[p]    = 1'b1;
          press_start[p] = now_ms;
        end
        prev_level[p] = w.level;
        return;
      end
      prev_level[p] = w.level;
      if (!pressing[p]) return;
      dur            = now_ms - press_start[p];
      pressing[p]    = 1'b0;
      last_event[p]  = now_ms;
      click.event_pad  = PAD_W'(p);
      click.click_kind = (dur >= TIME_W'(long_click)) ? CLICK_LONG : CLICK_SHORT;
      click.press_ms   = (dur > TIME_W'(16'hFFFF)) ? 16'hFFFF : dur[DUR_W-1:0];
      pending_clicks.push_back(click);
    endfunction

    function void check_click(out_word_t got, longint stamp);
      out_word_t want;
      if (pending_clicks.size() == 0) begin
        errors++;
        $display("%0t ns: click word with none expected, expected none, got pad %0d kind %0d ms %0d",
                 stamp, got.event_pad, got.click_kind, got.press_ms);
        return;
      end
      want = pending_clicks.pop_front();
      clicks_checked++;
      if (want.click_kind == CLICK_LONG) long_clicks++;
      if (got.event_pad !== want.event_pad) begin
        errors++;
        $display("%0t ns: event_pad mismatch, expected %0d, got %0d",
                 stamp, want.event_pad, got.event_pad);
      end
      if (got.click_kind !== want.click_kind) begin
        errors++;
        $display("%0t ns: click_kind mismatch on pad %0d, expected %0d, got %0d",
                 stamp, want.event_pad, want.click_kind, got.click_kind);
      end
      if (got.press_ms !== want.press_ms) begin
        errors++;
        $display("%0t ns: press_ms mismatch on pad %0d, expected %0d, got %0d",
                 stamp, want.event_pad, want.press_ms, got.press_ms);
      end
    endfunction

    function void flush_leftovers(longint stamp);
      out_word_t want;
      while (pending_clicks.size() != 0) begin
        want = pending_clicks.pop_front();
        errors++;
        $display("%0t ns: click never arrived, expected pad %0d kind %0d ms %0d, got none",
                 stamp, want.event_pad, want.click_kind, want.press_ms);
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
// Bench top: drives ticks and pad samples into the click detector and checks every click word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bclpd_pkg::*;
  import click_tb_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  click_scoreboard sb = new();

  // Idle odds in percent for each side, changed per phase
  int tx_idle = 22;
  int rx_idle = 53;
  // Request a long receiver hold-off; the receiver process clears it
  bit hold_req = 1'b0;

  int words_sent = 0;
  int in_stall_cycles = 0;

  button_click_long_press_detector_core #(
    .NUM_PADS(PADS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop in case the block hangs
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  // Watch both handshakes and the register port at each edge. Values read here are the
  // ones from before the edge, since every driver and the block update with nonblocking
  // assignments.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_stall) in_stall_cycles++;
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_click(out_word, $time);
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked so that the
  // block fills up and pushes back on its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  function automatic logic [MASK_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MASK_W-1:0];
  endfunction

  // Tick words carry random pad and level bits, which the block must ignore
  function automatic in_word_t tick_word();
    in_word_t w;
    w.operation = OP_TICK;
    w.pad       = PAD_W'($urandom);
    w.level     = 1'($urandom);
    return w;
  endfunction

  function automatic in_word_t sample_word(int p, bit lvl);
    in_word_t w;
    w.operation = OP_SAMPLE;
    w.pad       = PAD_W'(p);
    w.level     = lvl;
    return w;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.operation = 1'($urandom);
    w.pad       = PAD_W'($urandom_range(0, 63));
    w.level     = 1'($urandom);
    return w;
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high into the
  // next word unless a random gap drops it first.
  task automatic send_word(in_word_t w);
    if ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    // out-of-range pad samples are dropped by the block and do not count
    if (w.operation == OP_TICK || w.pad < PADS) words_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(tick_word());
  endtask

  // Drop valid, drain every expected click, then give in-flight words time to retire
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Write all four registers on back-to-back edges; the 16-bit ones get junk above bit 15
  task automatic apply_setting(logic [DUR_W-1:0] deb, logic [DUR_W-1:0] lng,
                               logic [MASK_W-1:0] alm, logic [MASK_W-1:0] en);
    logic [CFG_W-1:0] junk;
    junk = rand40();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= {junk[CFG_W-1:DUR_W], deb};
    @(posedge clk);
    cfg_index <= CFG_LONG_CLICK;
    cfg_wdata <= {~junk[CFG_W-1:DUR_W], lng};
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_wdata <= alm;
    @(posedge clk);
    cfg_index <= CFG_ENABLE;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One press on a random pad: optional re-arm, a few ticks to clear debounce, the press,
  // maybe a repeated active sample, a hold with stray words mixed in, then the release.
  task automatic press_episode();
    int p;
    bit act;
    int span;
    p    = $urandom_range(0, PADS - 1);
    act  = sb.active_level(p);
    span = (sb.long_click < 20) ? int'(sb.long_click) + 3 : 20;
    if ($urandom_range(0, 1)) send_word(sample_word(p, !act));
    send_ticks($urandom_range(0, 6));
    send_word(sample_word(p, act));
    if ($urandom_range(0, 3) == 0) send_word(sample_word(p, act));
    repeat ($urandom_range(0, span)) begin
      if ($urandom_range(0, 5) == 0) send_word(noise_word());
      else send_word(tick_word());
    end
    send_word(sample_word(p, !act));
  endtask

  task automatic run_random(int budget);
    int goal;
    goal = words_sent + budget;
    while (words_sent < goal) begin
      if ($urandom_range(0, 99) < 20) send_word(noise_word());
      else press_episode();
    end
  endtask

  initial begin
    int s;
    int cap;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: every pad disabled, so samples only record the level. Out-of-range pads
    // are dropped and a tick ignores its pad and level bits.
    send_word(sample_word(0, 1'b1));
    send_word(sample_word(40, 1'b1));
    send_word(sample_word(63, 1'b0));
    send_word(tick_word());
    send_word(sample_word(0, 1'b0));
    settle();
    apply_setting(16'd2, 16'd3, '0, '1);

    // Right after reset the debounce window still covers every pad
    send_word(sample_word(5, 1'b1));
    send_word(sample_word(5, 1'b0));
    send_ticks(3);
    // Clean press with a repeated active sample, short click
    send_word(sample_word(5, 1'b1));
    send_word(sample_word(5, 1'b1));
    send_word(tick_word());
    send_word(sample_word(5, 1'b0));
    // Re-press inside the debounce window, then release while idle
    send_word(sample_word(5, 1'b1));
    send_word(sample_word(5, 1'b0));
    // Press held exactly the threshold on the top pad, long click
    send_word(sample_word(39, 1'b1));
    send_ticks(3);
    send_word(sample_word(39, 1'b0));
    settle();

    // All pads active low, zero thresholds
    apply_setting(16'd0, 16'd0, '1, '1);
    send_word(sample_word(0, 1'b0));
    send_word(tick_word());
    send_word(sample_word(0, 1'b1));
    // Start a press, then flip polarity under it: the press must vanish
    send_word(sample_word(1, 1'b0));
    settle();
    apply_setting(16'd0, 16'd0, '0, '1);
    send_word(sample_word(1, 1'b0));

    // Random phases: each setting runs a batch of press episodes and stray words
    for (s = 0; s < 8; s++) begin
      settle();
      if (s < 3) begin
        tx_idle = 22;
        rx_idle = 53;
      end else if (s < 6) begin
        tx_idle = 53;
        rx_idle = 22;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      case (s)
        0: apply_setting(16'd3, 16'd6, rand40(), '1);
        1: apply_setting(16'd0, 16'hFFFF, '0, rand40());
        2: apply_setting(16'hFFFF, 16'd0, rand40(), '1);
        3: apply_setting(16'($urandom_range(0, 10)), 16'($urandom_range(0, 20)), '1, '1);
        4: apply_setting(16'd1, 16'd0, rand40(), rand40() | rand40());
        5: apply_setting(16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)), rand40(), '0);
        6: apply_setting(16'd0, 16'd4, rand40(), '1);
        default: apply_setting(16'($urandom_range(0, 8)), 16'($urandom_range(0, 16)),
                               rand40(), rand40() | rand40());
      endcase
      // Hold the receiver off while the sender keeps pushing, so the block backs up
      if (s == 6) hold_req = 1'b1;
      run_random((s == 2 || s == 5) ? 150 : 250);
    end

    // Drain, then wait out the pipeline for stray words
    in_valid <= 1'b0;
    cap = 0;
    while (sb.pending() != 0 && cap < 5000) begin
      @(posedge clk);
      cap++;
    end
    repeat (10) @(posedge clk);
    sb.flush_leftovers($time);

    $display("Run covered %0d input words and checked %0d click words (%0d long).",
             words_sent, sb.clicks_checked, sb.long_clicks);
    $display("Input side was held back for %0d cycles; %0d errors seen.",
             in_stall_cycles, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bclpd_pkg.sv
rtl/bclpd_ram.sv
rtl/button_click_long_press_detector_core.sv
sim/click_tb_pkg.sv
sim/tb_top.sv
